// ===== rtl/lzw_pkg.sv =====
// Package for the LZW byte encoder: widths, codes, controller states and
// the command/status bundles between controller and datapath. No dependencies.
`default_nettype none
package lzw_pkg;

    localparam int CODE_W        = 12;
    localparam int BYTE_W        = 8;
    localparam int KEY_W         = CODE_W + BYTE_W;
    localparam int DICT_SIZE_DEF = 4096;
    localparam int END_CODE      = 256;
    localparam int FIRST_FREE    = END_CODE + 1;
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_EMIT_MISS,
        S_EMIT_CUR,
        S_EMIT_EOF
    } t_state;

    typedef struct packed {
        logic load_in;
        logic search;
        logic take_hit;
        logic emit_miss;
        logic emit_cur;
        logic emit_eof;
    } t_dp_cmd;

    typedef struct packed {
        logic have_current;
        logic last_in;
        logic hit;
        logic miss;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

// ===== rtl/lzw_byte_encoder.sv =====
// LZW byte encoder, 12-bit codes. A byte is taken only while idle, after the last byte is
// done. With a match open, scan the n = next_free - 257 learned entries at one read per
// cycle, up to a miss past the last entry or a hit at entry 257 + k. Each code is then
// loaded into the output register while it is free; a last byte adds two codes (match,
// then 256). Synchronous active-low reset clears the match, free pointer and output;
// dictionary contents are not cleared. Depends on lzw_pkg, lzw_ctrl, lzw_datapath.
`default_nettype none
module lzw_byte_encoder #(
    parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [lzw_pkg::TDATA_IN_W-1:0]     s_axis_tdata,   // [7:0] data_byte
    input  wire                                s_axis_tlast,   // last_byte
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [lzw_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,   // [11:0] code, [15:12] zero
    output logic                               m_axis_tlast    // run_last
);

    lzw_pkg::t_dp_cmd    cmd;
    lzw_pkg::t_dp_status status;
    logic [lzw_pkg::CODE_W-1:0] code;

    lzw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    lzw_datapath #(
        .DICT_SIZE (DICT_SIZE)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_code      (code),
        .o_run_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(lzw_pkg::TDATA_OUT_W - lzw_pkg::CODE_W){1'b0}}, code};

endmodule
`default_nettype wire

// ===== rtl/lzw_ctrl.sv =====
// Controller state machine of the LZW byte encoder.
// Depends on lzw_pkg for states and command/status bundles.
`default_nettype none
module lzw_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    input  wire               i_in_last,
    output logic              o_in_ready,
    input  lzw_pkg::t_dp_status i_status,
    output lzw_pkg::t_dp_cmd  o_cmd
);

    lzw_pkg::t_state r_state;
    lzw_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lzw_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            lzw_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.have_current) begin
                        n_state = lzw_pkg::S_SEARCH;
                    end else if (i_in_last) begin
                        n_state = lzw_pkg::S_EMIT_CUR;
                    end
                end
            end
            lzw_pkg::S_SEARCH: begin
                if (i_status.hit) begin
                    n_state = i_status.last_in ? lzw_pkg::S_EMIT_CUR : lzw_pkg::S_IDLE;
                end else if (i_status.miss) begin
                    n_state = lzw_pkg::S_EMIT_MISS;
                end
            end
            lzw_pkg::S_EMIT_MISS: begin
                if (i_status.out_free) begin
                    n_state = i_status.last_in ? lzw_pkg::S_EMIT_CUR : lzw_pkg::S_IDLE;
                end
            end
            lzw_pkg::S_EMIT_CUR: begin
                if (i_status.out_free) begin
                    n_state = lzw_pkg::S_EMIT_EOF;
                end
            end
            lzw_pkg::S_EMIT_EOF: begin
                if (i_status.out_free) begin
                    n_state = lzw_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lzw_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            lzw_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            lzw_pkg::S_SEARCH: begin
                o_cmd.search   = ~i_status.hit;
                o_cmd.take_hit = i_status.hit;
            end
            lzw_pkg::S_EMIT_MISS: begin
                o_cmd.emit_miss = i_status.out_free;
            end
            lzw_pkg::S_EMIT_CUR: begin
                o_cmd.emit_cur = i_status.out_free;
            end
            lzw_pkg::S_EMIT_EOF: begin
                o_cmd.emit_eof = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== rtl/lzw_datapath.sv =====
// Datapath of the LZW byte encoder: dictionary memory, linear search,
// match/free-slot registers and the output register. Depends on lzw_pkg.
`default_nettype none
module lzw_datapath #(
    parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  lzw_pkg::t_dp_cmd                   i_cmd,
    output lzw_pkg::t_dp_status                o_status,
    input  wire  [lzw_pkg::BYTE_W-1:0]         i_byte,
    input  wire                                i_last,
    input  wire                                i_out_ready,
    output logic                               o_out_valid,
    output logic [lzw_pkg::CODE_W-1:0]         o_code,
    output logic                               o_run_last
);

    localparam int IDX_W = $clog2(DICT_SIZE);
    localparam int NF_W  = IDX_W + 1;
    localparam int CW    = lzw_pkg::CODE_W;
    localparam int BW    = lzw_pkg::BYTE_W;
    localparam int KW    = lzw_pkg::KEY_W;
    localparam logic [NF_W-1:0] NF_FIRST = NF_W'(lzw_pkg::FIRST_FREE);
    localparam logic [NF_W-1:0] NF_FULL  = NF_W'(DICT_SIZE);

    logic [KW-1:0]    mem [DICT_SIZE];
    logic [KW-1:0]    r_rd_data;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_rd_pend;
    logic             n_rd_pend;
    logic [NF_W-1:0]  r_idx;
    logic [NF_W-1:0]  n_idx;
    logic [NF_W-1:0]  r_next_free;
    logic [NF_W-1:0]  n_next_free;
    logic [CW-1:0]    r_current;
    logic [CW-1:0]    n_current;
    logic             r_have;
    logic             n_have;
    logic [BW-1:0]    r_byte;
    logic             r_last_in;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CW-1:0]    r_code;
    logic             r_run_last;
    logic [CW-1:0]    n_code;
    logic             n_run_last;
    logic             out_free;
    logic             rd_issue;
    logic             hit;
    logic [KW-1:0]    key;
    logic [CW+IDX_W-1:0] hit_wide;

    assign out_free = ~r_out_valid | i_out_ready;
    assign key      = {r_current, r_byte};
    assign rd_issue = i_cmd.search & (r_idx < r_next_free);
    assign hit      = r_rd_pend & (r_rd_data == key);
    assign hit_wide = {{CW{1'b0}}, r_rd_idx};

    always_comb begin
        o_status.have_current = r_have;
        o_status.last_in      = r_last_in;
        o_status.hit          = hit;
        o_status.miss         = ~r_rd_pend & (r_idx >= r_next_free);
        o_status.out_free     = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (rd_issue) begin
            r_rd_data <= mem[r_idx[IDX_W-1:0]];
            r_rd_idx  <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.emit_miss) begin
            mem[r_next_free[IDX_W-1:0]] <= key;
        end
    end

    always_comb begin
        n_rd_pend   = r_rd_pend;
        n_idx       = r_idx;
        n_next_free = r_next_free;
        n_current   = r_current;
        n_have      = r_have;
        n_out_valid = r_out_valid;
        n_code      = r_code;
        n_run_last  = r_run_last;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_in) begin
            n_rd_pend = 1'b0;
            n_idx     = NF_FIRST;
            if (!r_have) begin
                n_current = {{(CW-BW){1'b0}}, i_byte};
                n_have    = 1'b1;
            end else if (r_next_free >= NF_FULL) begin
                n_next_free = NF_FIRST;
            end
        end
        if (i_cmd.search) begin
            n_rd_pend = rd_issue;
            if (rd_issue) begin
                n_idx = r_idx + NF_W'(1);
            end
        end
        if (i_cmd.take_hit) begin
            n_current = hit_wide[CW-1:0];
            n_rd_pend = 1'b0;
        end
        if (i_cmd.emit_miss) begin
            n_out_valid = 1'b1;
            n_code      = r_current;
            n_run_last  = ~r_last_in;
            n_next_free = r_next_free + NF_W'(1);
            n_current   = {{(CW-BW){1'b0}}, r_byte};
        end
        if (i_cmd.emit_cur) begin
            n_out_valid = 1'b1;
            n_code      = r_current;
            n_run_last  = 1'b0;
        end
        if (i_cmd.emit_eof) begin
            n_out_valid = 1'b1;
            n_code      = CW'(lzw_pkg::END_CODE);
            n_run_last  = 1'b1;
            n_next_free = NF_FIRST;
            n_current   = '0;
            n_have      = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend   <= 1'b0;
            r_idx       <= NF_FIRST;
            r_next_free <= NF_FIRST;
            r_current   <= '0;
            r_have      <= 1'b0;
            r_last_in   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend   <= n_rd_pend;
            r_idx       <= n_idx;
            r_next_free <= n_next_free;
            r_current   <= n_current;
            r_have      <= n_have;
            r_out_valid <= n_out_valid;
            if (i_cmd.load_in) begin
                r_last_in <= i_last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_byte;
        end
        r_code     <= n_code;
        r_run_last <= n_run_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_code      = r_code;
    assign o_run_last  = r_run_last;

endmodule
`default_nettype wire

// ===== dv/lzw_byte_encoder_checker.sv =====
// Scoreboard for the LZW byte encoder: follows byte and code transfers,
// keeps its own copy of the dictionary and match, and compares every code.
// Depends on lzw_pkg.
module lzw_byte_encoder_checker #(
    parameter int DICT_SIZE = lzw_pkg::DICT_SIZE_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,
    input  wire                                      s_axis_tvalid,
    input  wire                                      s_axis_tready,
    input  wire  [lzw_pkg::TDATA_IN_W-1:0]           s_axis_tdata,   // [7:0] data_byte
    input  wire                                      s_axis_tlast,   // last_byte
    input  wire                                      m_axis_tvalid,
    input  wire                                      m_axis_tready,
    input  wire  [lzw_pkg::TDATA_OUT_W-1:0]          m_axis_tdata,   // [11:0] code
    input  wire                                      m_axis_tlast,   // run_last
    output int                                       o_fail_count,
    output int                                       o_pending,
    output int                                       o_codes_checked,
    output int                                       o_dict_wraps,
    output int                                       o_carried_wraps
);

    typedef struct packed {
        logic [lzw_pkg::CODE_W-1:0] code;
        logic                       run_last;
    } t_code_word;

    t_code_word                 pending_codes[$];
    logic [lzw_pkg::KEY_W-1:0]  dict_mem [DICT_SIZE];
    int                         free_slot;
    logic [lzw_pkg::CODE_W-1:0] match_code;
    bit                         match_open;

    initial begin
        o_fail_count    = 0;
        o_pending       = 0;
        o_codes_checked = 0;
        o_dict_wraps    = 0;
        o_carried_wraps = 0;
        free_slot       = lzw_pkg::FIRST_FREE;
        match_code      = '0;
        match_open      = 1'b0;
    end

    function automatic int lookup_pair(input logic [lzw_pkg::CODE_W-1:0] prefix,
                                       input logic [lzw_pkg::BYTE_W-1:0] data);
        logic [lzw_pkg::KEY_W-1:0] key;
        key = {prefix, data};
        for (int slot = lzw_pkg::FIRST_FREE; slot < free_slot && slot < DICT_SIZE;
             slot++) begin
            if (dict_mem[slot] === key) begin
                return slot;
            end
        end
        return -1;
    endfunction

    task automatic encode_byte(input logic [lzw_pkg::BYTE_W-1:0] data, input bit last);
        int hit;
        int queued;
        queued = pending_codes.size();
        if (!match_open) begin
            match_code = lzw_pkg::CODE_W'(data);
            match_open = 1'b1;
        end else begin
            if (free_slot >= DICT_SIZE) begin
                free_slot = lzw_pkg::FIRST_FREE;
                o_dict_wraps++;
                if (match_code >= lzw_pkg::CODE_W'(lzw_pkg::FIRST_FREE)) begin
                    o_carried_wraps++;
                end
            end
            hit = lookup_pair(match_code, data);
            if (hit >= 0) begin
                match_code = hit[lzw_pkg::CODE_W-1:0];
            end else begin
                pending_codes.push_back(t_code_word'{match_code, 1'b0});
                dict_mem[free_slot] = {match_code, data};
                free_slot++;
                match_code = lzw_pkg::CODE_W'(data);
            end
        end
        if (last) begin
            pending_codes.push_back(t_code_word'{match_code, 1'b0});
            pending_codes.push_back(
                t_code_word'{lzw_pkg::CODE_W'(lzw_pkg::END_CODE), 1'b1});
            free_slot  = lzw_pkg::FIRST_FREE;
            match_code = '0;
            match_open = 1'b0;
        end else if (pending_codes.size() > queued) begin
            pending_codes[pending_codes.size() - 1].run_last = 1'b1;
        end
    endtask

    task automatic check_code();
        t_code_word want;
        if (pending_codes.size() == 0) begin
            $display("%0t: unexpected code %0d (tlast %0b), expected none",
                     $time, m_axis_tdata[lzw_pkg::CODE_W-1:0], m_axis_tlast);
            o_fail_count++;
        end else begin
            want = pending_codes.pop_front();
            o_codes_checked++;
            if (m_axis_tdata[lzw_pkg::CODE_W-1:0] !== want.code) begin
                $display("%0t: code mismatch, expected %0d, got %0d",
                         $time, want.code, m_axis_tdata[lzw_pkg::CODE_W-1:0]);
                o_fail_count++;
            end
            if (m_axis_tdata[lzw_pkg::TDATA_OUT_W-1:lzw_pkg::CODE_W] !== '0) begin
                $display("%0t: tdata padding mismatch, expected 0, got %0h",
                         $time, m_axis_tdata[lzw_pkg::TDATA_OUT_W-1:lzw_pkg::CODE_W]);
                o_fail_count++;
            end
            if (m_axis_tlast !== want.run_last) begin
                $display("%0t: tlast mismatch on code %0d, expected %0b, got %0b",
                         $time, want.code, want.run_last, m_axis_tlast);
                o_fail_count++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pending_codes.delete();
            free_slot  = lzw_pkg::FIRST_FREE;
            match_code = '0;
            match_open = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_code();
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encode_byte(s_axis_tdata[lzw_pkg::BYTE_W-1:0], s_axis_tlast);
            end
        end
        o_pending = pending_codes.size();
    end

endmodule

// ===== dv/lzw_byte_encoder_tb.sv =====
// Top of the LZW byte encoder bench: clock, reset, byte streams, and input idles and output
// back-pressure in four phases; verdict from the scoreboard.
// Depends on lzw_pkg, lzw_byte_encoder and lzw_byte_encoder_checker.
module lzw_byte_encoder_tb;

    localparam int DICT_SIZE       = 512;
    localparam int PHASE_BYTES     = 25;
    localparam int SEND_IDLE_PCT [4] = '{0, 48, 0, 23};
    localparam int RECV_STALL_PCT[4] = '{0, 0, 48, 23};

    logic                            i_clk         = 1'b0;
    logic                            i_rst_n       = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [lzw_pkg::TDATA_IN_W-1:0]  s_axis_tdata  = '0;   // [7:0] data_byte
    logic                            s_axis_tlast  = 1'b0; // last_byte
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [lzw_pkg::TDATA_OUT_W-1:0] m_axis_tdata;         // [11:0] code, [15:12] zero
    logic                            m_axis_tlast;         // run_last

    int fail_count;
    int pending_count;
    int codes_checked;
    int dict_wraps;
    int carried_wraps;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int bytes_sent = 0;
    int streams_sent = 0;

    lzw_byte_encoder #(
        .DICT_SIZE(DICT_SIZE)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    lzw_byte_encoder_checker #(
        .DICT_SIZE(DICT_SIZE)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tlast   (m_axis_tlast),
        .o_fail_count   (fail_count),
        .o_pending      (pending_count),
        .o_codes_checked(codes_checked),
        .o_dict_wraps   (dict_wraps),
        .o_carried_wraps(carried_wraps)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #16000000;
        $display("FAIL lzw_byte_encoder");
        $finish;
    end

    task automatic send_byte(input logic [lzw_pkg::BYTE_W-1:0] data, input bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = data;
        s_axis_tlast  = last;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        @(negedge i_clk);
        bytes_sent++;
        if (last) begin
            streams_sent++;
        end
    endtask

    task automatic send_stream(input logic [lzw_pkg::BYTE_W-1:0] data[]);
        foreach (data[i]) begin
            send_byte(data[i], i == data.size() - 1);
        end
    endtask

    // spread_pct: share of bytes drawn from the full range, the rest from a
    // four-letter alphabet so that matches grow into learned codes
    task automatic send_random_stream(input int len, input int spread_pct);
        logic [lzw_pkg::BYTE_W-1:0] letters[4];
        logic [lzw_pkg::BYTE_W-1:0] data;
        foreach (letters[i]) begin
            letters[i] = lzw_pkg::BYTE_W'($urandom_range(0, 255));
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(99) < spread_pct) begin
                data = lzw_pkg::BYTE_W'($urandom_range(0, 255));
            end else begin
                data = letters[$urandom_range(0, 3)];
            end
            send_byte(data, i == len - 1);
        end
    endtask

    initial begin
        int phase_start;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_stream('{8'h00});
        send_stream('{8'hFF});
        send_stream('{8'h41, 8'h42, 8'h41, 8'h42, 8'h41, 8'h42});
        send_stream('{8'h80, 8'h7F});
        send_stream('{8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA, 8'hAA});
        send_stream('{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h55});

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            phase_start    = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                if ($urandom_range(7) == 0) begin
                    send_random_stream($urandom_range(13, 40), $urandom_range(0, 100));
                end else begin
                    send_random_stream($urandom_range(1, 12), $urandom_range(0, 100));
                end
            end
        end

        s_axis_tvalid  = 1'b0;
        recv_stall_pct = 0;
        while (pending_count != 0) begin
            @(negedge i_clk);
        end
        repeat (DICT_SIZE + 16) @(negedge i_clk);

        $display("Sent %0d bytes in %0d streams, checked %0d codes.",
                 bytes_sent, streams_sent, codes_checked);
        $display("Dictionary wrapped %0d times, %0d with a learned match carried over.",
                 dict_wraps, carried_wraps);
        if (fail_count == 0) begin
            $display("PASS lzw_byte_encoder");
        end else begin
            $display("FAIL lzw_byte_encoder");
        end
        $finish;
    end

endmodule
